>>> hdl/flc_pkg.sv
// ----------------------------------------------------------------------------
// flc_pkg
// Shared constants for the frustum line clipper: default widths, register
// map and reset values, divider stage sizing.
// ----------------------------------------------------------------------------
package flc_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int T_FRAC_BITS_DEF = 16;

    // quotient bits resolved per divider pipeline stage
    localparam int DIV_STEPS = 4;

    // register indexes
    localparam int REG_FRONT_PLANE_Z    = 0;
    localparam int REG_BACK_PLANE_DEPTH = 1;

    // reset values, Q16.16
    localparam logic [63:0] FRONT_PLANE_Z_RESET    = 64'hFFFF_FFFF_FFFF_E666; // -0.1 (raw -6554)
    localparam logic [63:0] BACK_PLANE_DEPTH_RESET = 64'd26214400;            // 400.0

endpackage

>>> hdl/flc_div.sv
// ----------------------------------------------------------------------------
// flc_div
// Pipelined restoring divider for the plane parameter t = a / b, a <= b.
// Gives the quotient with T_FRAC_BITS fraction bits and a flag for a > b.
// ----------------------------------------------------------------------------
module flc_div
    import flc_pkg::*;
#(
    parameter int MAG_W       = 33,
    parameter int T_FRAC_BITS = 16
)(
    input  logic                   clk,
    input  logic                   en,
    input  logic [MAG_W-1:0]       dividend,
    input  logic [MAG_W-1:0]       divisor,
    output logic [T_FRAC_BITS:0]   quotient,
    output logic                   over
);

    localparam int NSTEP = T_FRAC_BITS + 1;
    localparam int NST   = (NSTEP + DIV_STEPS - 1) / DIV_STEPS;
    localparam int RW    = MAG_W + 1;
    localparam int QW    = T_FRAC_BITS + 1;

    logic [RW-1:0]    r_reg    [NST];
    logic [QW-1:0]    q_reg    [NST];
    logic [MAG_W-1:0] b_reg    [NST];
    logic             over_reg [NST];

    logic [RW-1:0]    r_in     [NST];
    logic [QW-1:0]    q_in     [NST];
    logic [MAG_W-1:0] b_in     [NST];
    logic             over_in  [NST];

    logic [RW-1:0]    r_next   [NST];
    logic [QW-1:0]    q_next   [NST];

    assign r_in[0]    = {1'b0, dividend};
    assign q_in[0]    = '0;
    assign b_in[0]    = divisor;
    assign over_in[0] = dividend > divisor;

    for (genvar g = 0; g < NST; g++)
    begin : g_stage
        if (g > 0)
        begin : g_link
            assign r_in[g]    = r_reg[g-1];
            assign q_in[g]    = q_reg[g-1];
            assign b_in[g]    = b_reg[g-1];
            assign over_in[g] = over_reg[g-1];
        end

        always_comb
        begin
            logic [RW-1:0] r;
            logic [QW-1:0] q;
            r = r_in[g];
            q = q_in[g];
            for (int k = 0; k < DIV_STEPS; k++)
            begin
                if (g * DIV_STEPS + k < NSTEP)
                begin
                    // first step yields the integer bit, no shift
                    if (g * DIV_STEPS + k != 0)
                    begin
                        r = {r[RW-2:0], 1'b0};
                        q = {q[QW-2:0], 1'b0};
                    end
                    if (r >= {1'b0, b_in[g]})
                    begin
                        q[0] = 1'b1;
                        r    = r - {1'b0, b_in[g]};
                    end
                end
            end
            r_next[g] = r;
            q_next[g] = q;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[g]    <= r_next[g];
                q_reg[g]    <= q_next[g];
                b_reg[g]    <= b_in[g];
                over_reg[g] <= over_in[g];
            end
        end
    end

    assign quotient = q_reg[NST-1];
    assign over     = over_reg[NST-1];

endmodule

>>> hdl/frustum_line_clipper.sv
// ----------------------------------------------------------------------------
// frustum_line_clipper
// Parametric 3D segment clipping against the canonical perspective frustum
// with configurable front and back planes.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------
//  in       | in_valid / in_stall    | start_x/y/z, end_x/y/z
//  out      | out_valid / out_stall  | visible, clip_start_x/y/z, clip_end_x/y/z
//  cfg      | psel/penable/pready    | paddr, pwdata, prdata, pwrite
//
//  One segment per cycle unless a result is held at the output. The six
//  plane dividers are pipelined alongside the other stages.
//  rst_n clears all valid bits and loads the plane registers' reset values.
//  A stalled result holds the whole pipeline; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module frustum_line_clipper
    import flc_pkg::*;
#(
    parameter  int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter  int T_FRAC_BITS = T_FRAC_BITS_DEF,
    localparam int PDATA_W     = (COORD_WIDTH > 32) ? 64 : 32,
    localparam int PADDR_W     = (COORD_WIDTH > 32) ? 4 : 3
)(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [COORD_WIDTH-1:0] start_x,
    input  logic signed [COORD_WIDTH-1:0] start_y,
    input  logic signed [COORD_WIDTH-1:0] start_z,
    input  logic signed [COORD_WIDTH-1:0] end_x,
    input  logic signed [COORD_WIDTH-1:0] end_y,
    input  logic signed [COORD_WIDTH-1:0] end_z,

    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          visible,
    output logic signed [COORD_WIDTH-1:0] clip_start_x,
    output logic signed [COORD_WIDTH-1:0] clip_start_y,
    output logic signed [COORD_WIDTH-1:0] clip_start_z,
    output logic signed [COORD_WIDTH-1:0] clip_end_x,
    output logic signed [COORD_WIDTH-1:0] clip_end_y,
    output logic signed [COORD_WIDTH-1:0] clip_end_z,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [PADDR_W-1:0]            paddr,
    input  logic [PDATA_W-1:0]            pwdata,
    output logic [PDATA_W-1:0]            prdata,
    output logic                          pready
);

    localparam int W   = COORD_WIDTH;
    localparam int F   = T_FRAC_BITS;
    localparam int DW  = W + 2;
    localparam int MW  = W + 1;
    localparam int TW  = F + 2;
    localparam int NST = (F + 1 + DIV_STEPS - 1) / DIV_STEPS;
    localparam logic [TW-1:0] T_ONE  = TW'(1) << F;
    localparam logic [TW-1:0] T_OVER = T_ONE + TW'(1);

    typedef struct packed {
        logic [2:0][W-1:0] s;
        logic [2:0][W-1:0] e;
        logic [2:0][W-1:0] dmag;
        logic [2:0]        dneg;
    } coord_t;

    typedef struct packed {
        logic d_pos;
        logic d_neg;
        logic n_pos;
        logic n_zero;
        logic sdiff;
    } plane_t;

    typedef struct packed {
        logic          ok;
        logic [TW-1:0] te;
        logic [TW-1:0] tl;
    } tstate_t;

    function automatic tstate_t plane_apply(tstate_t cur, plane_t p, logic [TW-1:0] t);
        tstate_t nx;
        nx = cur;
        if (p.d_pos)
        begin
            if ($signed(t) > $signed(cur.tl))
                nx.ok = 1'b0;
            else if ($signed(t) > $signed(cur.te))
                nx.te = t;
        end
        else if (p.d_neg)
        begin
            if ($signed(t) < $signed(cur.te))
                nx.ok = 1'b0;
            else if ($signed(t) < $signed(cur.tl))
                nx.tl = t;
        end
        else if (p.n_pos)
        begin
            nx.ok = 1'b0;
        end
        return nx;
    endfunction

    function automatic logic [W-1:0] add_scaled(logic [W-1:0] s, logic [W-1:0] p,
                                                 logic neg);
        logic [W:0] sp;
        logic [W:0] sum;
        sp  = {1'b0, p};
        sum = {s[W-1], s} + (neg ? -sp : sp);
        return sum[W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic signed [W-1:0] fz_reg;
    logic [W-2:0]        bd_reg;
    logic                cfg_wr;
    logic                cfg_idx;

    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[PADDR_W-1];
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fz_reg <= FRONT_PLANE_Z_RESET[W-1:0];
            bd_reg <= BACK_PLANE_DEPTH_RESET[W-2:0];
        end
        else if (cfg_wr)
        begin
            if (cfg_idx == 1'(REG_FRONT_PLANE_Z))
                fz_reg <= pwdata[W-1:0];
            else
                bd_reg <= pwdata[W-2:0];
        end
    end

    always_comb
    begin
        case (cfg_idx)
            1'(REG_FRONT_PLANE_Z):    prdata = PDATA_W'(fz_reg);
            1'(REG_BACK_PLANE_DEPTH): prdata = PDATA_W'(bd_reg);
            default:                  prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // pipeline control: the whole pipe advances unless the result is held
    // ------------------------------------------------------------------
    logic en;
    logic out_valid_reg;

    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    // stage 1: deltas
    logic                   v1_reg;
    logic [2:0][W-1:0]      s1_reg, e1_reg;
    logic [2:0][W:0]        d1_reg;
    logic [2:0][W-1:0]      s1_next, e1_next;
    logic [2:0][W:0]        d1_next;

    always_comb
    begin
        s1_next = {start_z, start_y, start_x};
        e1_next = {end_z, end_y, end_x};
        for (int i = 0; i < 3; i++)
            d1_next[i] = {e1_next[i][W-1], e1_next[i]} - {s1_next[i][W-1], s1_next[i]};
    end

    // stage 2: plane numerators and denominators
    logic                   v2_reg;
    logic signed [DW-1:0]   dn2_reg [6];
    logic signed [DW-1:0]   nm2_reg [6];
    coord_t                 cd2_reg;
    logic signed [DW-1:0]   dn2_next [6];
    logic signed [DW-1:0]   nm2_next [6];
    coord_t                 cd2_next;

    always_comb
    begin
        logic signed [DW-1:0] ds [3];
        logic signed [DW-1:0] ss [3];
        logic signed [DW-1:0] fzx;
        logic signed [DW-1:0] bdx;
        logic [W:0]           dn;
        for (int i = 0; i < 3; i++)
        begin
            ds[i] = DW'($signed(d1_reg[i]));
            ss[i] = DW'($signed(s1_reg[i]));
        end
        fzx = DW'(fz_reg);
        bdx = DW'(bd_reg);

        dn2_next[0] = -ds[0] - ds[2];  nm2_next[0] =  ss[0] + ss[2];   // right
        dn2_next[1] =  ds[0] - ds[2];  nm2_next[1] = -ss[0] + ss[2];   // left
        dn2_next[2] =  ds[1] - ds[2];  nm2_next[2] = -ss[1] + ss[2];   // bottom
        dn2_next[3] = -ds[1] - ds[2];  nm2_next[3] =  ss[1] + ss[2];   // top
        dn2_next[4] = -ds[2];          nm2_next[4] =  ss[2] - fzx;     // front
        dn2_next[5] =  ds[2];          nm2_next[5] = -ss[2] - bdx;     // back

        cd2_next.s = s1_reg;
        cd2_next.e = e1_reg;
        for (int i = 0; i < 3; i++)
        begin
            dn                  = -d1_reg[i];
            cd2_next.dneg[i]    = d1_reg[i][W];
            cd2_next.dmag[i]    = d1_reg[i][W] ? dn[W-1:0] : d1_reg[i][W-1:0];
        end
    end

    // stage 3: magnitudes and sign classes for the dividers
    logic                   v3_reg;
    logic [MW-1:0]          a3_reg [6];
    logic [MW-1:0]          b3_reg [6];
    plane_t [5:0]           pl3_reg;
    coord_t                 cd3_reg;
    logic [MW-1:0]          a3_next [6];
    logic [MW-1:0]          b3_next [6];
    plane_t [5:0]           pl3_next;

    always_comb
    begin
        logic [DW-1:0] nn;
        logic [DW-1:0] nd;
        for (int i = 0; i < 6; i++)
        begin
            nn = -nm2_reg[i];
            nd = -dn2_reg[i];
            a3_next[i] = nm2_reg[i][DW-1] ? nn[MW-1:0] : nm2_reg[i][MW-1:0];
            b3_next[i] = dn2_reg[i][DW-1] ? nd[MW-1:0] : dn2_reg[i][MW-1:0];
            pl3_next[i].d_neg  = dn2_reg[i][DW-1];
            pl3_next[i].d_pos  = !dn2_reg[i][DW-1] && (dn2_reg[i] != '0);
            pl3_next[i].n_zero = (nm2_reg[i] == '0);
            pl3_next[i].n_pos  = !nm2_reg[i][DW-1] && (nm2_reg[i] != '0);
            pl3_next[i].sdiff  = pl3_next[i].n_pos != pl3_next[i].d_pos;
        end
    end

    // dividers, with the rest of the item carried alongside
    logic [F:0]             q_div    [6];
    logic                   over_div [6];

    for (genvar gi = 0; gi < 6; gi++)
    begin : g_div
        flc_div #(
            .MAG_W       (MW),
            .T_FRAC_BITS (F)
        ) u_div (
            .clk      (clk),
            .en       (en),
            .dividend (a3_reg[gi]),
            .divisor  (b3_reg[gi]),
            .quotient (q_div[gi]),
            .over     (over_div[gi])
        );
    end

    logic                   vd_reg  [NST];
    coord_t                 cdd_reg [NST];
    plane_t [5:0]           pld_reg [NST];

    // combine A: planes right, left, bottom
    logic                   vca_reg;
    tstate_t                tsa_reg;
    logic [2:0][TW-1:0]     ta_reg;
    plane_t [2:0]           pla_reg;
    coord_t                 cda_reg;
    tstate_t                tsa_next;
    logic [5:0][TW-1:0]     t_all;

    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            if (pld_reg[NST-1][i].n_zero)
                t_all[i] = '0;
            else if (pld_reg[NST-1][i].sdiff)
                t_all[i] = '1;              // any negative quotient acts as -1 LSB
            else if (over_div[i])
                t_all[i] = T_OVER;          // beyond 1.0
            else
                t_all[i] = {1'b0, q_div[i]};
        end
        tsa_next.ok = 1'b1;
        tsa_next.te = '0;
        tsa_next.tl = T_ONE;
        for (int i = 0; i < 3; i++)
            tsa_next = plane_apply(tsa_next, pld_reg[NST-1][i], t_all[i]);
    end

    // combine B: planes top, front, back
    logic                   vcb_reg;
    tstate_t                tsb_reg;
    coord_t                 cdb_reg;
    tstate_t                tsb_next;

    always_comb
    begin
        tsb_next = tsa_reg;
        for (int i = 0; i < 3; i++)
            tsb_next = plane_apply(tsb_next, pla_reg[i], ta_reg[i]);
    end

    // multiply: |delta| * t, scaled back to coordinate units
    logic                   vm_reg;
    logic [2:0][W-1:0]      ps_reg, pe_reg;
    logic                   sel_s_reg, sel_e_reg, ok_m_reg;
    coord_t                 cdm_reg;
    logic [2:0][W-1:0]      ps_next, pe_next;

    always_comb
    begin
        logic [W+F:0] prod_s;
        logic [W+F:0] prod_e;
        for (int i = 0; i < 3; i++)
        begin
            prod_s     = (W+F+1)'(cdb_reg.dmag[i]) * (W+F+1)'(tsb_reg.te[F:0]);
            prod_e     = (W+F+1)'(cdb_reg.dmag[i]) * (W+F+1)'(tsb_reg.tl[F:0]);
            ps_next[i] = prod_s[W+F-1:F];
            pe_next[i] = prod_e[W+F-1:F];
        end
    end

    // output stage: new endpoints from the original start point
    logic [2:0][W-1:0]      os_next, oe_next;
    logic [2:0][W-1:0]      os_reg, oe_reg;
    logic                   vis_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            os_next[i] = sel_s_reg ? add_scaled(cdm_reg.s[i], ps_reg[i], cdm_reg.dneg[i])
                                   : cdm_reg.s[i];
            oe_next[i] = sel_e_reg ? add_scaled(cdm_reg.s[i], pe_reg[i], cdm_reg.dneg[i])
                                   : cdm_reg.e[i];
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            for (int g = 0; g < NST; g++)
                vd_reg[g] <= 1'b0;
            vca_reg       <= 1'b0;
            vcb_reg       <= 1'b0;
            vm_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            vd_reg[0]     <= v3_reg;
            for (int g = 1; g < NST; g++)
                vd_reg[g] <= vd_reg[g-1];
            vca_reg       <= vd_reg[NST-1];
            vcb_reg       <= vca_reg;
            vm_reg        <= vcb_reg;
            out_valid_reg <= vm_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg     <= s1_next;
            e1_reg     <= e1_next;
            d1_reg     <= d1_next;

            dn2_reg    <= dn2_next;
            nm2_reg    <= nm2_next;
            cd2_reg    <= cd2_next;

            a3_reg     <= a3_next;
            b3_reg     <= b3_next;
            pl3_reg    <= pl3_next;
            cd3_reg    <= cd2_reg;

            cdd_reg[0] <= cd3_reg;
            pld_reg[0] <= pl3_reg;
            for (int g = 1; g < NST; g++)
            begin
                cdd_reg[g] <= cdd_reg[g-1];
                pld_reg[g] <= pld_reg[g-1];
            end

            tsa_reg    <= tsa_next;
            ta_reg     <= t_all[5:3];
            pla_reg    <= pld_reg[NST-1][5:3];
            cda_reg    <= cdd_reg[NST-1];

            tsb_reg    <= tsb_next;
            cdb_reg    <= cda_reg;

            ps_reg     <= ps_next;
            pe_reg     <= pe_next;
            sel_s_reg  <= tsb_reg.ok && ($signed(tsb_reg.te) > $signed(TW'(0)));
            sel_e_reg  <= tsb_reg.ok && ($signed(tsb_reg.tl) < $signed(T_ONE));
            ok_m_reg   <= tsb_reg.ok;
            cdm_reg    <= cdb_reg;

            os_reg     <= os_next;
            oe_reg     <= oe_next;
            vis_reg    <= ok_m_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign visible      = vis_reg;
    assign clip_start_x = os_reg[0];
    assign clip_start_y = os_reg[1];
    assign clip_start_z = os_reg[2];
    assign clip_end_x   = oe_reg[0];
    assign clip_end_y   = oe_reg[1];
    assign clip_end_z   = oe_reg[2];

endmodule

>>> hdl/flc_chk.sv
// ----------------------------------------------------------------------------
// flc_chk
// Port-level checks for the frustum line clipper, bound to the top level.
// ----------------------------------------------------------------------------
module flc_chk
    import flc_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int PDATA_W     = 32,
    parameter int PADDR_W     = 3
)(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_stall,
    input logic                   out_valid,
    input logic                   out_stall,
    input logic                   visible,
    input logic [COORD_WIDTH-1:0] clip_start_x,
    input logic                   psel,
    input logic                   penable,
    input logic                   pwrite,
    input logic [PADDR_W-1:0]     paddr,
    input logic [PDATA_W-1:0]     pwdata,
    input logic [PDATA_W-1:0]     prdata
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(visible) && $stable(clip_start_x))
        else $error("held result changed");

    // input back-pressure only when a result is held at the output
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall not tied to held result");

    // no result shown once reset has been seen
    a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("result valid during reset");

    // a written register reads back
    a_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite ##1 psel && !pwrite && paddr == $past(paddr)
        |-> prdata[COORD_WIDTH-2:0] == $past(pwdata[COORD_WIDTH-2:0]))
        else $error("register readback mismatch");

endmodule

bind frustum_line_clipper flc_chk #(
    .COORD_WIDTH (COORD_WIDTH),
    .PDATA_W     (PDATA_W),
    .PADDR_W     (PADDR_W)
) u_flc_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .visible      (visible),
    .clip_start_x (clip_start_x),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata)
);
